### rtl/cle_pkg.sv
// Shared types and constants for the cursor line editor.
// Depends on nothing; imported by every module of the block but cle_ram.
package cle_pkg;

  localparam int unsigned CNT_W = 7;

  typedef enum logic [1:0] {
    ACT_TYPE  = 2'd0,
    ACT_LEFT  = 2'd1,
    ACT_RIGHT = 2'd2,
    ACT_BKSP  = 2'd3
  } cle_action_e;

  typedef enum logic [1:0] {
    RD_MOVE,
    RD_CURSOR,
    RD_EMIT
  } cle_rdsel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OP,
    ST_MOVE,
    ST_CUR,
    ST_CAP,
    ST_EMIT
  } cle_state_e;

  typedef struct packed {
    cle_action_e action;
    logic [7:0]  typed_char;
  } cle_in_t;

  typedef struct packed {
    logic [7:0]       text_char;
    logic             text_valid;
    logic [7:0]       cursor_char;
    logic             cursor_at_end;
    logic [CNT_W-1:0] line_length;
    logic [CNT_W-1:0] cursor_pos;
    logic             dropped;
    logic             last;
  } cle_out_t;

  typedef struct packed {
    logic       latch;
    logic       do_op;
    logic       do_move;
    logic       clr_idx;
    logic       cap_cursor;
    logic       emit;
    cle_rdsel_e rd_sel;
  } cle_cmd_t;

  typedef struct packed {
    logic move_ok;
    logic out_free;
    logic emit_last;
  } cle_sts_t;

endpackage

### rtl/cursor_line_editor.sv
// Single-line editor with cursor, two character stacks in RAM.
// Per request: accept, edit (and a cursor move where one applies), cursor read and capture,
// then the line replays one character per cycle while the output is not stalled.
// A new request is accepted only after the last character of the line has been emitted.
// Reset clears counts and control; stack contents stay undefined until written.
module cursor_line_editor #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cle_pkg::cle_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cle_pkg::cle_out_t out_data_o
);
  import cle_pkg::*;

  cle_cmd_t cmd;
  cle_sts_t sts;

  cle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cle_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/cle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module cle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/cle_ctrl.sv
// Command sequencer of the line editor: accept, edit, cursor move, cursor read, line replay.
// Depends on cle_pkg; drives cle_dp through cle_cmd_t, watches cle_sts_t.
module cle_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cle_pkg::cle_sts_t sts_i,
  output cle_pkg::cle_cmd_t cmd_o
);
  import cle_pkg::*;

  cle_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_OP;
      end
      ST_OP: begin
        state_d = sts_i.move_ok ? ST_MOVE : ST_CUR;
      end
      ST_MOVE: state_d = ST_CUR;
      ST_CUR:  state_d = ST_CAP;
      ST_CAP:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.out_free && sts_i.emit_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.rd_sel     = RD_EMIT;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      ST_OP: begin
        cmd_o.do_op  = 1'b1;
        cmd_o.rd_sel = RD_MOVE;
      end
      ST_MOVE: begin
        cmd_o.do_move = 1'b1;
        cmd_o.rd_sel  = RD_MOVE;
      end
      ST_CUR: begin
        cmd_o.clr_idx = 1'b1;
        cmd_o.rd_sel  = RD_CURSOR;
      end
      ST_CAP: begin
        cmd_o.cap_cursor = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### rtl/cle_dp.sv
// Datapath of the line editor: two character stacks, counts, replay index,
// output register. Depends on cle_pkg and cle_ram; controlled by cle_ctrl.
module cle_dp #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cle_pkg::cle_in_t   in_data_i,
  input  cle_pkg::cle_cmd_t  cmd_i,
  output cle_pkg::cle_sts_t  sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cle_pkg::cle_out_t  out_data_o
);
  import cle_pkg::*;

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_LEN);

  cle_in_t          req_q;
  logic [CNT_W-1:0] bcnt_q, bcnt_d, acnt_q, acnt_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [7:0]       cur_q;
  logic             drop_q;
  logic             out_valid_q;
  cle_out_t         out_q;

  logic [CNT_W-1:0] len;
  logic             full;
  logic             b_we, a_we;
  logic [AW-1:0]    b_waddr, a_waddr, b_raddr, a_raddr;
  logic [7:0]       b_wdata, a_wdata, b_rdata, a_rdata;
  logic [CNT_W-1:0] a_emit_idx;
  logic             emit_fire;
  logic             mv_fire;

  assign len       = bcnt_q + acnt_q;
  assign full      = (len >= MaxCnt);
  assign emit_fire = cmd_i.emit && sts_o.out_free;
  assign mv_fire   = cmd_i.do_move;

  assign sts_o.move_ok = ((req_q.action == ACT_LEFT) && (bcnt_q != '0))
                      || ((req_q.action == ACT_RIGHT) && (acnt_q != '0)
                          && (bcnt_q < MaxCnt));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.emit_last = (len == '0) || (idx_q == len - CNT_W'(1));

  // Stack writes and count updates
  always_comb begin
    bcnt_d  = bcnt_q;
    acnt_d  = acnt_q;
    b_we    = 1'b0;
    a_we    = 1'b0;
    b_waddr = bcnt_q[AW-1:0];
    a_waddr = acnt_q[AW-1:0];
    b_wdata = req_q.typed_char;
    a_wdata = b_rdata;
    if (cmd_i.do_op) begin
      case (req_q.action)
        ACT_TYPE: begin
          if (!full) begin
            b_we   = 1'b1;
            bcnt_d = bcnt_q + CNT_W'(1);
          end
        end
        ACT_BKSP: begin
          if (bcnt_q != '0) bcnt_d = bcnt_q - CNT_W'(1);
        end
        default: begin
          bcnt_d = bcnt_q;
        end
      endcase
    end
    if (cmd_i.do_move) begin
      if (req_q.action == ACT_LEFT) begin
        a_we   = 1'b1;
        bcnt_d = bcnt_q - CNT_W'(1);
        acnt_d = acnt_q + CNT_W'(1);
      end else begin
        b_we    = 1'b1;
        b_wdata = a_rdata;
        acnt_d  = acnt_q - CNT_W'(1);
        bcnt_d  = bcnt_q + CNT_W'(1);
      end
    end
  end

  // Look ahead one index so read data matches idx_q during the line replay
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.clr_idx) begin
      idx_d = '0;
    end else if (emit_fire) begin
      idx_d = idx_q + CNT_W'(1);
    end
  end

  assign a_emit_idx = len - CNT_W'(1) - idx_d;

  always_comb begin
    b_raddr = idx_d[AW-1:0];
    a_raddr = a_emit_idx[AW-1:0];
    case (cmd_i.rd_sel)
      RD_MOVE: begin
        b_raddr = AW'(bcnt_q - CNT_W'(1));
        a_raddr = AW'(acnt_q - CNT_W'(1));
      end
      RD_CURSOR: begin
        a_raddr = AW'(acnt_q - CNT_W'(1));
      end
      default: begin
        b_raddr = idx_d[AW-1:0];
      end
    endcase
  end

  cle_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_before_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  cle_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_after_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q      <= '0;
      acnt_q      <= '0;
      idx_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bcnt_q <= bcnt_d;
      acnt_q <= acnt_d;
      idx_q  <= idx_d;
      if (cmd_i.do_op) begin
        drop_q <= (req_q.action == ACT_TYPE) && full;
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= in_data_i;
    end
    if (cmd_i.cap_cursor) begin
      cur_q <= (acnt_q != '0) ? a_rdata : 8'd0;
    end
    if (emit_fire) begin
      out_q.text_char     <= (len == '0) ? 8'd0 : ((idx_q < bcnt_q) ? b_rdata : a_rdata);
      out_q.text_valid    <= (len != '0);
      out_q.cursor_char   <= cur_q;
      out_q.cursor_at_end <= (acnt_q == '0);
      out_q.line_length   <= len;
      out_q.cursor_pos    <= bcnt_q;
      out_q.dropped       <= drop_q;
      out_q.last          <= sts_o.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len <= MaxCnt)
    else $error("line length above capacity");

  a_move_keeps_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv_fire |=> (len == $past(len)))
    else $error("cursor move changed line length");

  a_pos_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.cursor_pos <= out_data_o.line_length))
    else $error("cursor past end of line");

  a_mid_run_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.last) |-> out_data_o.text_valid)
    else $error("empty character inside a run");

endmodule

### test/cle_line_checker.sv
// Scoreboard for the cursor line editor: watches the request and result channels,
// keeps its own copy of the two character stacks and checks every replayed
// line. Depends on cle_pkg.
module cle_line_checker #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  cle_pkg::cle_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  cle_pkg::cle_out_t out_data_i,
  output int unsigned       errors_o,
  output int unsigned       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cle_pkg::*;

  logic [7:0]  left_chars [MAX_LEN];
  logic [7:0]  right_chars [MAX_LEN];
  int unsigned left_cnt;
  int unsigned right_cnt;
  cle_out_t    expected_line [$];

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $time, what);
    errors_o++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  task automatic edit_and_replay(input cle_in_t req);
    int unsigned len;
    int unsigned k;
    logic        drop;
    cle_out_t    res;
    drop = 1'b0;
    case (req.action)
      ACT_TYPE: begin
        if (left_cnt + right_cnt >= MAX_LEN) begin
          drop = 1'b1;
        end else begin
          left_chars[left_cnt] = req.typed_char;
          left_cnt++;
        end
      end
      ACT_LEFT: begin
        if (left_cnt > 0 && right_cnt < MAX_LEN) begin
          left_cnt--;
          right_chars[right_cnt] = left_chars[left_cnt];
          right_cnt++;
        end
      end
      ACT_RIGHT: begin
        if (right_cnt > 0 && left_cnt < MAX_LEN) begin
          right_cnt--;
          left_chars[left_cnt] = right_chars[right_cnt];
          left_cnt++;
        end
      end
      ACT_BKSP: begin
        if (left_cnt > 0) begin
          left_cnt--;
        end
      end
      default: begin
        drop = 1'b0;
      end
    endcase
    len = left_cnt + right_cnt;
    res = '0;
    res.cursor_at_end = (right_cnt == 0);
    res.cursor_char   = (right_cnt == 0) ? 8'h00 : right_chars[right_cnt - 1];
    res.line_length   = CNT_W'(len);
    res.cursor_pos    = CNT_W'(left_cnt);
    res.dropped       = drop;
    if (len == 0) begin
      res.last = 1'b1;
      expected_line.push_back(res);
    end else begin
      for (k = 0; k < len; k++) begin
        res.text_char  = (k < left_cnt) ? left_chars[k] : right_chars[len - 1 - k];
        res.text_valid = 1'b1;
        res.last       = (k == len - 1);
        expected_line.push_back(res);
      end
    end
  endtask

  task automatic compare_result(input cle_out_t got);
    cle_out_t want;
    if (expected_line.size() == 0) begin
      report_mismatch("result with no command outstanding");
    end else begin
      want = expected_line.pop_front();
      check_field("text_char", 32'(got.text_char), 32'(want.text_char));
      check_field("text_valid", 32'(got.text_valid), 32'(want.text_valid));
      check_field("cursor_char", 32'(got.cursor_char), 32'(want.cursor_char));
      check_field("cursor_at_end", 32'(got.cursor_at_end), 32'(want.cursor_at_end));
      check_field("line_length", 32'(got.line_length), 32'(want.line_length));
      check_field("cursor_pos", 32'(got.cursor_pos), 32'(want.cursor_pos));
      check_field("dropped", 32'(got.dropped), 32'(want.dropped));
      check_field("last", 32'(got.last), 32'(want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_cnt  = 0;
      right_cnt = 0;
      errors_o  = 0;
      pending_o = 0;
      expected_line.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        compare_result(out_data_i);
      end
      if (in_valid_i && in_ready_i) begin
        edit_and_replay(in_data_i);
      end
      pending_o = expected_line.size();
    end
  end

endmodule

### test/cursor_line_editor_tb.sv
// Top of the cursor line editor testbench: clock, reset, command stimulus, result
// back-pressure and the final verdict. Depends on cle_pkg, cle_line_checker and the RTL.
module cursor_line_editor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cle_pkg::*;

  typedef enum {
    SEG_FILL,
    SEG_WANDER,
    SEG_SWEEP_L,
    SEG_SWEEP_R,
    SEG_DRAIN
  } seg_kind_e;

  localparam int unsigned MAX_LEN      = 64;
  localparam int unsigned NUM_SEGS     = 12;
  localparam int unsigned SEG_ITEMS    = 38;
  localparam int unsigned STALL_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES  = 80;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        out_ready = 1'b0;
  cle_in_t     in_data   = '0;
  logic        in_ready;
  logic        out_valid;
  cle_out_t    out_data;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        stall_req     = 1'b0;
  int unsigned errors;
  int unsigned pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cursor_line_editor #(
    .MAX_LEN(MAX_LEN)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  cle_line_checker #(
    .MAX_LEN(MAX_LEN)
  ) i_line_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin : receiver
    logic        stall_seen;
    int unsigned stall_left;
    stall_seen = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_cmd(input cle_action_e act, input logic [7:0] ch);
    cle_in_t req;
    req.action     = act;
    req.typed_char = ch;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_line_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  function automatic cle_action_e pick_action(input seg_kind_e kind);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (kind)
      SEG_FILL: begin
        return (r < 88) ? ACT_TYPE : (r < 92) ? ACT_LEFT : (r < 96) ? ACT_RIGHT : ACT_BKSP;
      end
      SEG_SWEEP_L: begin
        return (r < 95) ? ACT_LEFT : (r < 97) ? ACT_TYPE : (r < 99) ? ACT_RIGHT : ACT_BKSP;
      end
      SEG_SWEEP_R: begin
        return (r < 95) ? ACT_RIGHT : (r < 97) ? ACT_TYPE : (r < 99) ? ACT_LEFT : ACT_BKSP;
      end
      SEG_DRAIN: begin
        return (r < 70) ? ACT_BKSP : (r < 80) ? ACT_LEFT : (r < 90) ? ACT_TYPE : ACT_RIGHT;
      end
      default: begin
        return cle_action_e'(r[1:0]);
      end
    endcase
  endfunction

  initial begin : stimulus
    seg_kind_e   plan [NUM_SEGS];
    int unsigned s;
    int unsigned n;
    plan = '{SEG_FILL, SEG_FILL, SEG_SWEEP_L, SEG_SWEEP_L, SEG_FILL, SEG_WANDER,
             SEG_SWEEP_R, SEG_SWEEP_R, SEG_DRAIN, SEG_DRAIN, SEG_WANDER, SEG_DRAIN};
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct <= 8;
    recv_idle_pct <= 53;

    // empty line first: every move and delete is a no-op; then edits at both line ends
    send_cmd(ACT_LEFT, 8'hA5);
    send_cmd(ACT_BKSP, 8'h5A);
    send_cmd(ACT_RIGHT, 8'hFF);
    send_cmd(ACT_TYPE, 8'h00);
    send_cmd(ACT_TYPE, 8'hFF);
    send_cmd(ACT_TYPE, 8'h55);
    send_cmd(ACT_TYPE, 8'hAA);
    send_cmd(ACT_RIGHT, 8'h0F);
    send_cmd(ACT_LEFT, 8'hF0);
    send_cmd(ACT_LEFT, 8'h00);
    send_cmd(ACT_TYPE, 8'h01);
    send_cmd(ACT_LEFT, 8'h80);
    send_cmd(ACT_LEFT, 8'h7F);
    send_cmd(ACT_LEFT, 8'hFF);
    send_cmd(ACT_LEFT, 8'h33);
    send_cmd(ACT_BKSP, 8'hCC);
    send_cmd(ACT_TYPE, 8'h80);
    send_cmd(ACT_RIGHT, 8'h00);
    send_cmd(ACT_BKSP, 8'hFF);
    send_cmd(ACT_RIGHT, 8'h11);
    send_cmd(ACT_RIGHT, 8'h22);
    send_cmd(ACT_RIGHT, 8'h44);
    send_cmd(ACT_BKSP, 8'h88);
    wait_line_drained();

    for (s = 0; s < NUM_SEGS; s++) begin
      if (s == 4) begin
        send_idle_pct <= 53;
        recv_idle_pct <= 8;
      end else if (s == 8) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      if (s == 2) begin
        stall_req <= ~stall_req;
      end
      if (s == 6) begin
        wait_line_drained();
      end
      for (n = 0; n < SEG_ITEMS; n++) begin
        send_cmd(pick_action(plan[s]), 8'($urandom_range(0, 255)));
      end
    end

    wait_line_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS cursor_line_editor");
    end else begin
      $display("FAIL cursor_line_editor");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("FAIL cursor_line_editor");
    $finish;
  end

endmodule
